FILE: rtl/core/bfts_pkg.sv
// Shared types and constants for the brute-force tour search block.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package bfts_pkg;

    localparam int MAX_NODES_DEF   = 8;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int SLOT_BITS       = 3;
    localparam int ROUTE_BITS      = 21;
    localparam int SUM_OUT_BITS    = 19;
    localparam int BEST_BITS       = 20;
    localparam int CNT_BITS        = 4;
    localparam logic [CNT_BITS-1:0] NODE_COUNT_RESET = 4'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic init;       // load first ordering, restart best sums
        logic clr_sum;    // begin a new tour sum
        logic add_edge;   // add edge prev -> seq[pos]
        logic add_close;  // add edge prev -> 0 and compare
        logic adv_find;   // scan one step for the pivot
        logic adv_swap;   // scan one step for the successor and swap
        logic adv_rev;    // one step of the suffix reversal
    } bfts_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic walk_last;  // position index is at the final slot
        logic pivot_done; // pivot scan finished this step
        logic no_pivot;   // pivot scan found none: last ordering
        logic swap_done;  // successor found and swapped
        logic rev_done;   // reversal complete
    } bfts_stat_t;

endpackage

FILE: rtl/core/bfts_ctrl.sv
// Controller state machine of the tour search.
// Depends on bfts_pkg for the command and status structs.
`timescale 1ns / 1ps

module bfts_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic                one_node,
    input  bfts_pkg::bfts_stat_t stat,
    output bfts_pkg::bfts_cmd_t  cmd,
    output logic                idle,
    output logic                finish
);
    import bfts_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INIT  = 7'b0000010,
        S_WALK  = 7'b0000100,
        S_CLOSE = 7'b0001000,
        S_FIND  = 7'b0010000,
        S_SWAP  = 7'b0100000,
        S_REV   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        finish     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init    = 1'b1;
                cmd.clr_sum = 1'b1;
                state_next  = one_node ? S_CLOSE : S_WALK;
            end
            S_WALK:
            begin
                cmd.add_edge = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                cmd.add_close = 1'b1;
                state_next    = S_FIND;
            end
            S_FIND:
            begin
                cmd.adv_find = 1'b1;
                if (stat.no_pivot)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.pivot_done)
                begin
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                cmd.adv_swap = 1'b1;
                if (stat.swap_done)
                begin
                    state_next = S_REV;
                end
            end
            S_REV:
            begin
                cmd.adv_rev = 1'b1;
                if (stat.rev_done)
                begin
                    cmd.clr_sum = 1'b1;
                    state_next  = S_WALK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);

endmodule

FILE: rtl/core/bfts_dp.sv
// Datapath of the tour search: weight memories, ordering, sums and best tours.
// Depends on bfts_pkg for the command and status structs.
`timescale 1ns / 1ps

module bfts_dp #(
    parameter int WEIGHT_BITS = bfts_pkg::WEIGHT_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [2:0]                          wr_row,
    input  logic [2:0]                          wr_col,
    input  logic [15:0]                         wr_dist,
    input  logic [15:0]                         wr_time,
    input  logic [bfts_pkg::CNT_BITS-1:0]       n_eff,
    input  bfts_pkg::bfts_cmd_t                 cmd,
    output bfts_pkg::bfts_stat_t                stat,
    output logic [bfts_pkg::BEST_BITS-1:0]      best_d,
    output logic [bfts_pkg::ROUTE_BITS-1:0]     best_d_route,
    output logic [bfts_pkg::BEST_BITS-1:0]      best_t,
    output logic [bfts_pkg::ROUTE_BITS-1:0]     best_t_route
);
    import bfts_pkg::*;

    localparam int MAX_NODES = MAX_NODES_DEF;
    localparam int NB    = $clog2(MAX_NODES);
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int AB    = 2 * NB;
    localparam int SUMB  = WEIGHT_BITS + $clog2(MAX_NODES) + 1;
    localparam int NSLOT = ROUTE_BITS / SLOT_BITS;

    // Memories are written by load items and read through registered ports.
    // Every entry starts at one; valid bits hold that value until written.
    logic [WEIGHT_BITS-1:0] dist_mem [DEPTH];
    logic [WEIGHT_BITS-1:0] time_mem [DEPTH];
    logic [DEPTH-1:0]       vld_reg;

    logic [NB-1:0]  seq_reg [MAX_NODES];
    logic [NB-1:0]  prev_reg;
    logic [CNT_BITS-1:0] pos_reg, scan_reg, jdx_reg;
    logic [SUMB-1:0] dsum_reg, tsum_reg;
    logic [BEST_BITS-1:0] bd_reg, bt_reg;
    logic [ROUTE_BITS-1:0] bdr_reg, btr_reg;
    logic [CNT_BITS-1:0] len;
    logic [AB-1:0] wa, ra;
    logic [NB-1:0] nxt;
    logic [WEIGHT_BITS-1:0] rd_d, rd_t;
    logic [SUMB-1:0] dtot, ttot;
    logic [ROUTE_BITS-1:0] cur_route;

    assign len = n_eff - 1'b1;
    assign wa  = {wr_row[NB-1:0], wr_col[NB-1:0]};

    // The edge address is formed from the previous node and the next one;
    // the weight comes back registered in the next cycle for the adder.
    assign nxt = cmd.add_close ? '0 : seq_reg[pos_reg[NB-1:0]];
    assign ra  = {prev_reg, nxt};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dist_mem[wa] <= WEIGHT_BITS'(wr_dist);
            time_mem[wa] <= WEIGHT_BITS'(wr_time);
        end
        rd_d <= dist_mem[ra];
        rd_t <= time_mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wa] <= 1'b1;
        end
    end

    // Read data is registered: pending-add flags follow the commands to match it.
    logic add_p_reg, close_p_reg, vld_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_p_reg   <= 1'b0;
            close_p_reg <= 1'b0;
        end
        else
        begin
            add_p_reg   <= cmd.add_edge | cmd.add_close;
            close_p_reg <= cmd.add_close;
        end
    end

    always_ff @(posedge clk)
    begin
        vld_p_reg <= vld_reg[ra];
    end

    logic [WEIGHT_BITS-1:0] ed, et;
    assign ed   = vld_p_reg ? rd_d : WEIGHT_BITS'(1);
    assign et   = vld_p_reg ? rd_t : WEIGHT_BITS'(1);
    assign dtot = dsum_reg + SUMB'(ed);
    assign ttot = tsum_reg + SUMB'(et);

    always_comb
    begin
        cur_route = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (i < MAX_NODES && CNT_BITS'(i) < len)
            begin
                cur_route[SLOT_BITS*i +: SLOT_BITS] = SLOT_BITS'(seq_reg[i % MAX_NODES]);
            end
        end
    end

    // Permutation stepping over one index per cycle.
    logic [CNT_BITS-1:0] pivot_reg;
    logic [CNT_BITS-1:0] scan_m1, piv_m1;
    logic [NB-1:0] s_a, s_b, s_p, s_j;
    assign scan_m1 = scan_reg - 1'b1;
    assign piv_m1  = pivot_reg - 1'b1;
    assign s_a = seq_reg[scan_m1[NB-1:0]];
    assign s_b = seq_reg[scan_reg[NB-1:0]];
    assign s_p = seq_reg[piv_m1[NB-1:0]];
    assign s_j = seq_reg[jdx_reg[NB-1:0]];

    always_comb
    begin
        stat = '0;
        stat.walk_last  = (pos_reg == len - 1'b1);
        stat.no_pivot   = (len < 2) || (scan_reg == 0);
        stat.pivot_done = (scan_reg != 0) && (s_a < s_b);
        stat.swap_done  = (s_j > s_p);
        stat.rev_done   = !(pos_reg < jdx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                seq_reg[i] <= NB'(i + 1);
            end
        end
        if (cmd.clr_sum)
        begin
            pos_reg  <= '0;
            prev_reg <= '0;
            dsum_reg <= '0;
            tsum_reg <= '0;
        end
        else if (add_p_reg && !close_p_reg)
        begin
            dsum_reg <= dtot;
            tsum_reg <= ttot;
        end
        if (cmd.add_edge)
        begin
            prev_reg <= nxt;
            pos_reg  <= pos_reg + 1'b1;
        end
        if (cmd.add_close)
        begin
            scan_reg <= len - 1'b1;
            jdx_reg  <= len - 1'b1;
        end
        if (cmd.adv_find && !(stat.pivot_done))
        begin
            scan_reg <= scan_reg - 1'b1;
        end
        if (cmd.adv_find && stat.pivot_done)
        begin
            pivot_reg <= scan_reg;
        end
        if (cmd.adv_swap)
        begin
            if (stat.swap_done)
            begin
                seq_reg[piv_m1[NB-1:0]]  <= s_j;
                seq_reg[jdx_reg[NB-1:0]] <= s_p;
                pos_reg <= pivot_reg;
                jdx_reg <= len - 1'b1;
            end
            else
            begin
                jdx_reg <= jdx_reg - 1'b1;
            end
        end
        if (cmd.adv_rev && !stat.rev_done)
        begin
            seq_reg[pos_reg[NB-1:0]] <= seq_reg[jdx_reg[NB-1:0]];
            seq_reg[jdx_reg[NB-1:0]] <= seq_reg[pos_reg[NB-1:0]];
            pos_reg <= pos_reg + 1'b1;
            jdx_reg <= jdx_reg - 1'b1;
        end
    end

    // The close edge lands in the cycle after add_close, the first find cycle;
    // the ordering is untouched until then because find only moves scan_reg and pivot_reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bd_reg  <= '1;
            bt_reg  <= '1;
            bdr_reg <= '0;
            btr_reg <= '0;
        end
        else if (cmd.init)
        begin
            bd_reg  <= '1;
            bt_reg  <= '1;
            bdr_reg <= '0;
            btr_reg <= '0;
        end
        else if (close_p_reg)
        begin
            if (BEST_BITS'(dtot) < bd_reg && SUMB'(BEST_BITS'(dtot)) == dtot)
            begin
                bd_reg  <= BEST_BITS'(dtot);
                bdr_reg <= cur_route;
            end
            if (BEST_BITS'(ttot) < bt_reg && SUMB'(BEST_BITS'(ttot)) == ttot)
            begin
                bt_reg  <= BEST_BITS'(ttot);
                btr_reg <= cur_route;
            end
        end
    end

    assign best_d       = bd_reg;
    assign best_d_route = bdr_reg;
    assign best_t       = bt_reg;
    assign best_t_route = btr_reg;

endmodule

FILE: rtl/core/brute_force_tour_search.sv
// Top level of the brute-force tour search block.
// Instantiates bfts_ctrl and bfts_dp; uses bfts_pkg.
//
// Usage: raise start with the item fields while busy is low; the beat is
// taken at that edge. cmd = write stores one distance and one travel-time
// entry (ignored if row or col is at or beyond the effective node count);
// busy stays low, so loads stream one per cycle. cmd = solve sets busy and
// walks every ordering of nodes 1..N-1 in lexicographic order. Each tour is
// a run of summing steps and one closing step, then the next-ordering step:
// the pivot scan, the successor scan and the reversal each move one index
// per cycle. All tours share the single adder pair and the one read port of
// each weight memory.
// When done, done pulses for one cycle with both minima and routes; the
// receiver cannot stall, so the result beat is taken at that edge.
// node_count is written over its own valid/ready channel; ready is high
// while the block is not busy.
// Reset clears both matrices to ones (through per-entry valid bits),
// sets node_count to 5 and leaves the block idle.
`timescale 1ns / 1ps

module brute_force_tour_search #(
    parameter int WEIGHT_BITS = bfts_pkg::WEIGHT_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  cmd,
    input  logic [2:0]                            row,
    input  logic [2:0]                            col,
    input  logic [15:0]                           distance,
    input  logic [15:0]                           travel_time,
    output logic                                  done,
    output logic [bfts_pkg::SUM_OUT_BITS-1:0]     shortest_distance,
    output logic [bfts_pkg::ROUTE_BITS-1:0]       shortest_route,
    output logic [bfts_pkg::SUM_OUT_BITS-1:0]     fastest_time,
    output logic [bfts_pkg::ROUTE_BITS-1:0]       fastest_route,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bfts_pkg::CNT_BITS-1:0]         cfg_data
);
    import bfts_pkg::*;

    localparam int MAX_NODES = MAX_NODES_DEF;

    logic [CNT_BITS-1:0] node_count_reg, n_eff;
    logic                accept, wr_ok, go, idle, finish, done_reg;
    bfts_cmd_t           dcmd;
    bfts_stat_t          dstat;
    logic [BEST_BITS-1:0] bd, bt;
    logic [ROUTE_BITS-1:0] bdr, btr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            node_count_reg <= cfg_data;
        end
    end

    // Zero acts as one node and anything above the maximum as the maximum.
    always_comb
    begin
        priority if (node_count_reg == '0)
            n_eff = CNT_BITS'(1);
        else if (node_count_reg > CNT_BITS'(MAX_NODES))
            n_eff = CNT_BITS'(MAX_NODES);
        else
            n_eff = node_count_reg;
    end

    assign busy      = !idle;
    assign cfg_ready = idle;
    assign accept    = start && !busy;
    assign go        = accept && (cmd == CMD_SOLVE);
    assign wr_ok     = accept && (cmd == CMD_WRITE)
                       && ({1'b0, row} < n_eff) && ({1'b0, col} < n_eff);

    bfts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .one_node (n_eff == CNT_BITS'(1)),
        .stat     (dstat),
        .cmd      (dcmd),
        .idle     (idle),
        .finish   (finish)
    );

    bfts_dp #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_ok),
        .wr_row       (row),
        .wr_col       (col),
        .wr_dist      (distance),
        .wr_time      (travel_time),
        .n_eff        (n_eff),
        .cmd          (dcmd),
        .stat         (dstat),
        .best_d       (bd),
        .best_d_route (bdr),
        .best_t       (bt),
        .best_t_route (btr)
    );

    // The last close-edge compare lands no later than the edge that ends the scan,
    // so the result is ready when done, registered from finish, is presented.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
        end
    end

    assign done              = done_reg;
    assign shortest_distance = bd[SUM_OUT_BITS-1:0];
    assign shortest_route    = bdr;
    assign fastest_time      = bt[SUM_OUT_BITS-1:0];
    assign fastest_route     = btr;

endmodule
